FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on i_clk, off while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/btp_pkg.sv
// ----------------------------------------------------------------------------
// btp_pkg
// Types and constants shared by the bencode token parser modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btp_pkg;

    // nesting and number limits
    localparam int MAX_DEPTH   = 16;
    localparam int NUM_BITS    = 32;
    localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
    localparam int ACC_W       = (NUM_BITS > 32) ? NUM_BITS : 32;
    localparam int PROD_W      = ACC_W + 4;
    localparam int VALUE_W     = 32;
    localparam int DEPTH_OUT_W = 5;
    localparam int REMAIN_W    = 31;

    // longest string length accepted
    localparam logic [ACC_W-1:0] STR_LIMIT = ACC_W'(32'h7FFF_FFFF);
    // two to the power NUM_BITS-1
    localparam logic [ACC_W-1:0] INT_HALF  = {{(ACC_W-1){1'b0}}, 1'b1} << (NUM_BITS - 1);

    // characters of the bencode text
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;

    typedef enum logic [2:0] {
        KIND_STR   = 3'd0,
        KIND_BYTE  = 3'd1,
        KIND_INT   = 3'd2,
        KIND_OPEN  = 3'd3,
        KIND_CLOSE = 3'd4,
        KIND_ERR   = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_UNEXPECTED = 3'd1,
        ERR_BAD_DIGIT  = 3'd2,
        ERR_CLOSE_ZERO = 3'd3,
        ERR_TOO_DEEP   = 3'd4,
        ERR_OVERFLOW   = 3'd5
    } t_err;

    // one token from the parse core
    typedef struct packed {
        logic                   valid;
        t_kind                  kind;
        logic [VALUE_W-1:0]     value;
        logic                   last;
        logic [DEPTH_OUT_W-1:0] depth;
        t_err                   err;
    } t_token;

endpackage

FILE: rtl/core/bencode_token_parser.sv
// ----------------------------------------------------------------------------
// bencode_token_parser
// Streaming bencode tokenizer: one byte in, at most one token out
// ----------------------------------------------------------------------------
// a byte is held in the input register, parsed, and its token, if any, is held
// in the token register; throughput: one byte per cycle while i_out_stall does not
// hold the token register; the two registers decouple the two channels
// reset: synchronous active-low i_rst_n clears the valid flags of both registers
// and all parse state (idle, depth zero); no warm-up after reset
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bencode_token_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_token_kind,
    output logic signed [31:0] o_token_value,
    output logic               o_last_byte,
    output logic [4:0]         o_nest_depth,
    output logic [2:0]         o_error_code
);
    import btp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_token     r_out_tok;

    logic       out_free;
    logic       proc;
    logic       in_accept;
    t_token     core_tok;

    logic       out_err;
    logic       out_ok;
    logic       out_last;
    logic       out_open;
    logic       in_held;

    // handshake: the input register drains whenever the token register can load
    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
        end
    end

    // parse step
    btp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_proc  (proc),
        .i_byte  (r_in_byte),
        .o_token (core_tok)
    );

    // token register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc && core_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_tok <= core_tok;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_token_kind  = r_out_tok.kind;
    assign o_token_value = r_out_tok.value;
    assign o_last_byte   = r_out_tok.last;
    assign o_nest_depth  = r_out_tok.depth;
    assign o_error_code  = r_out_tok.err;

    // conditions watched by the checks below
    assign out_err  = r_out_valid && (r_out_tok.kind == KIND_ERR);
    assign out_ok   = r_out_valid && (r_out_tok.kind != KIND_ERR);
    assign out_last = r_out_valid && r_out_tok.last;
    assign out_open = r_out_valid && (r_out_tok.kind == KIND_OPEN);
    assign in_held  = r_in_valid && r_out_valid && i_out_stall;

    // error tokens carry a code and depth zero; other tokens carry no code
    `ASSERT_IMPLIES(a_err_code, out_err, r_out_tok.err != ERR_NONE, "error token without a code")
    `ASSERT_IMPLIES(a_err_depth, out_err, r_out_tok.depth == '0, "error token with depth")
    `ASSERT_IMPLIES(a_ok_no_code, out_ok, r_out_tok.err == ERR_NONE, "error code on a good token")
    // last marker only on a body byte, list open always leaves some depth
    `ASSERT_IMPLIES(a_last_on_byte, out_last, r_out_tok.kind == KIND_BYTE, "stray last marker")
    `ASSERT_IMPLIES(a_open_depth, out_open, r_out_tok.depth != '0, "list open at depth zero")
    // a pending byte is kept while the token register is held
    `ASSERT_NEXT(a_in_held, in_held, r_in_valid && $stable(r_in_byte), "pending byte lost")

endmodule

FILE: rtl/core/btp_core.sv
// ----------------------------------------------------------------------------
// btp_core
// Parse state and per-byte token logic; one byte consumed per enabled cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btp_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_proc,
    input  logic [7:0]      i_byte,
    output btp_pkg::t_token o_token
);
    import btp_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_LEN,
        MODE_BODY,
        MODE_INT_FIRST,
        MODE_INT_SIGN,
        MODE_INT_DIGITS
    } t_mode;

    t_mode               r_mode,   n_mode;
    logic [ACC_W-1:0]    r_accum,  n_accum;
    logic                r_neg,    n_neg;
    logic [REMAIN_W-1:0] r_remain, n_remain;
    logic [DEPTH_W-1:0]  r_depth,  n_depth;

    logic                is_digit;
    logic [3:0]          digit_val;
    logic [ACC_W-1:0]    limit;
    logic [PROD_W-1:0]   prod;
    logic                over;
    logic [REMAIN_W-1:0] remain_dec;
    logic [ACC_W-1:0]    neg_accum;
    t_token              tok;

    // digit decode and times-ten accumulate with limit check
    always_comb begin
        is_digit   = (i_byte inside {[CH_ZERO:CH_NINE]});
        digit_val  = is_digit ? 4'(i_byte - CH_ZERO) : 4'd0;
        if (r_mode == MODE_LEN) begin
            limit = STR_LIMIT;
        end else begin
            limit = r_neg ? INT_HALF : INT_HALF - ACC_W'(1);
        end
        prod       = (PROD_W'(r_accum) << 3) + (PROD_W'(r_accum) << 1) + PROD_W'(digit_val);
        over       = prod > PROD_W'(limit);
        remain_dec = r_remain - REMAIN_W'(1);
        neg_accum  = ACC_W'(0) - r_accum;
    end

    // next state and token
    always_comb begin
        n_mode   = r_mode;
        n_accum  = r_accum;
        n_neg    = r_neg;
        n_remain = r_remain;
        n_depth  = r_depth;
        // every good token carries the list depth, after the change for an open or close
        tok      = '{valid: 1'b0, kind: KIND_ERR, value: '0, last: 1'b0,
                     depth: DEPTH_OUT_W'(r_depth), err: ERR_NONE};

        case (r_mode)
            MODE_LEN: begin
                if (is_digit) begin
                    if (over) begin
                        tok.valid = 1'b1;
                        tok.err   = ERR_OVERFLOW;
                    end else begin
                        n_accum = prod[ACC_W-1:0];
                    end
                end else if (i_byte != CH_COLON) begin
                    tok.valid = 1'b1;
                    tok.err   = ERR_BAD_DIGIT;
                end else begin
                    n_remain  = r_accum[REMAIN_W-1:0];
                    n_accum   = '0;
                    n_mode    = (r_accum != '0) ? MODE_BODY : MODE_IDLE;
                    tok.valid = 1'b1;
                    tok.kind  = KIND_STR;
                    tok.value = r_accum[VALUE_W-1:0];
                end
            end
            MODE_BODY: begin
                n_remain  = remain_dec;
                tok.valid = 1'b1;
                tok.kind  = KIND_BYTE;
                tok.value = VALUE_W'(i_byte);
                tok.last  = (remain_dec == '0);
                if (remain_dec == '0) begin
                    n_mode = MODE_IDLE;
                end
            end
            MODE_INT_FIRST, MODE_INT_SIGN: begin
                if (r_mode == MODE_INT_FIRST && i_byte == CH_MINUS) begin
                    n_neg  = 1'b1;
                    n_mode = MODE_INT_SIGN;
                end else if (!is_digit) begin
                    tok.valid = 1'b1;
                    tok.err   = ERR_BAD_DIGIT;
                end else if (over) begin
                    tok.valid = 1'b1;
                    tok.err   = ERR_OVERFLOW;
                end else begin
                    n_accum = prod[ACC_W-1:0];
                    n_mode  = MODE_INT_DIGITS;
                end
            end
            MODE_INT_DIGITS: begin
                if (is_digit) begin
                    if (over) begin
                        tok.valid = 1'b1;
                        tok.err   = ERR_OVERFLOW;
                    end else begin
                        n_accum = prod[ACC_W-1:0];
                    end
                end else if (i_byte != CH_E) begin
                    tok.valid = 1'b1;
                    tok.err   = ERR_BAD_DIGIT;
                end else begin
                    n_accum   = '0;
                    n_neg     = 1'b0;
                    n_mode    = MODE_IDLE;
                    tok.valid = 1'b1;
                    tok.kind  = KIND_INT;
                    tok.value = r_neg ? neg_accum[VALUE_W-1:0] : r_accum[VALUE_W-1:0];
                end
            end
            default: begin
                n_mode = MODE_IDLE;
                if (i_byte == CH_NUL) begin
                    n_accum  = '0;
                    n_neg    = 1'b0;
                    n_remain = '0;
                    n_depth  = '0;
                end else if (is_digit) begin
                    n_accum = ACC_W'(digit_val);
                    n_mode  = MODE_LEN;
                end else if (i_byte == CH_I) begin
                    n_accum = '0;
                    n_neg   = 1'b0;
                    n_mode  = MODE_INT_FIRST;
                end else if (i_byte == CH_L) begin
                    tok.valid = 1'b1;
                    if (r_depth >= DEPTH_W'(MAX_DEPTH)) begin
                        tok.err = ERR_TOO_DEEP;
                    end else begin
                        n_depth   = r_depth + DEPTH_W'(1);
                        tok.kind  = KIND_OPEN;
                        tok.depth = DEPTH_OUT_W'(n_depth);
                    end
                end else if (i_byte == CH_E) begin
                    tok.valid = 1'b1;
                    if (r_depth == '0) begin
                        tok.err = ERR_CLOSE_ZERO;
                    end else begin
                        n_depth   = r_depth - DEPTH_W'(1);
                        tok.kind  = KIND_CLOSE;
                        tok.depth = DEPTH_OUT_W'(n_depth);
                    end
                end else begin
                    tok.valid = 1'b1;
                    tok.err   = ERR_UNEXPECTED;
                end
            end
        endcase

        // any error drops the parser back to its reset state
        if (tok.valid && tok.err != ERR_NONE) begin
            tok.kind  = KIND_ERR;
            tok.value = '0;
            tok.depth = '0;
            n_mode    = MODE_IDLE;
            n_accum   = '0;
            n_neg     = 1'b0;
            n_remain  = '0;
            n_depth   = '0;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_accum  <= '0;
            r_neg    <= 1'b0;
            r_remain <= '0;
            r_depth  <= '0;
        end else if (i_proc) begin
            r_mode   <= n_mode;
            r_accum  <= n_accum;
            r_neg    <= n_neg;
            r_remain <= n_remain;
            r_depth  <= n_depth;
        end
    end

    assign o_token = tok;

endmodule
